FILE: hw/rtl/brle_pkg.sv
package brle_pkg;

  // Token kinds on the result channel
  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_SKIP    = 2'd1;
  localparam logic [1:0] KIND_REPEAT  = 2'd2;

  // Runs up to this length are gathered as literal bytes
  localparam logic [7:0] LITERAL_RUN_MAX = 8'd2;

  // Largest count that fits the token count field
  localparam int COUNT_MAX = 255;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;      // latch the input transfer
    logic run_inc;      // extend the open run
    logic run_load;     // open a run with the pending byte
    logic run_dec;      // one byte of the open run moved to the group
    logic run_clear;    // no open run
    logic lit_write;    // append the run byte to the literal group
    logic rd_issue;     // read the group entry at the flush index
    logic emit_lit;     // load one literal result
    logic emit_tok;     // load a skip or repeat result
    logic fill_clear;   // group emptied
    logic stream_last;  // results loaded now may close the image
  } brle_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic extend;       // incoming byte continues the open run
    logic run_zero;     // no open run
    logic run_long;     // open run is long enough for a token
    logic group_full;
    logic group_empty;
    logic idx_last;     // flush index is on the last group byte
    logic out_free;     // result register can take a result
    logic pend_last;    // latched byte was the final one
  } brle_sts_t;

endpackage

FILE: hw/rtl/byte_run_length_encoder_unit.sv
// Channel   Handshake             Payload
// input     in_valid / in_stall   data_byte, final_byte
// result    out_valid / out_stall token_kind, token_value, token_count,
//                                 element_end, stream_end
//
// A byte that extends the open run is taken without closing it; any other byte,
// and the final byte, closes the run: its bytes move into the literal group one
// at a time, or a long run becomes a token, and a final byte that opens a new
// run closes that one as well. A group is flushed before a token or on a full
// group, one literal result per byte through a single registered read port.
// Reset (rst, synchronous) empties the run and the group; no clearing pass.
// A stalled result holds the sequencer; input is stalled while a run closes.
module byte_run_length_encoder_unit #(
  parameter int LITERAL_GROUP_MAX = 16,
  parameter int RUN_LIMIT = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] token_value,
  output logic [7:0] token_count,
  output logic       element_end,
  output logic       stream_end
);
  import brle_pkg::*;

  brle_cmd_t cmd;
  brle_sts_t sts;

  // Sequencer
  brle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .final_byte (final_byte),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Run, group store and result register
  brle_datapath #(
    .LITERAL_GROUP_MAX (LITERAL_GROUP_MAX),
    .RUN_LIMIT         (RUN_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .token_value (token_value),
    .token_count (token_count),
    .element_end (element_end),
    .stream_end  (stream_end)
  );

endmodule

FILE: hw/rtl/brle_datapath.sv
module brle_datapath #(
  parameter int LITERAL_GROUP_MAX = 16,
  parameter int RUN_LIMIT = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  brle_pkg::brle_cmd_t cmd,
  output brle_pkg::brle_sts_t sts,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          token_kind,
  output logic [7:0]          token_value,
  output logic [7:0]          token_count,
  output logic                element_end,
  output logic                stream_end
);
  import brle_pkg::*;

  localparam int FW = $clog2(LITERAL_GROUP_MAX + 1);
  localparam int IW = $clog2(LITERAL_GROUP_MAX);
  localparam int RUN_CAP = (RUN_LIMIT > COUNT_MAX) ? COUNT_MAX : RUN_LIMIT;

  logic [7:0]    run_byte;
  logic [7:0]    run_length;
  logic [7:0]    pend_byte;
  logic          pend_last;
  logic [FW-1:0] fill;
  logic [IW-1:0] idx;
  logic [7:0]    store [LITERAL_GROUP_MAX];
  logic [7:0]    rd_data;

  // Status towards the controller
  always_comb begin
    sts.extend      = (run_length != 8'd0) && (data_byte == run_byte) &&
                      (run_length < 8'(RUN_CAP));
    sts.run_zero    = (run_length == 8'd0);
    sts.run_long    = (run_length > LITERAL_RUN_MAX);
    sts.group_full  = (fill == FW'(LITERAL_GROUP_MAX));
    sts.group_empty = (fill == '0);
    sts.idx_last    = (FW'(idx) == (fill - FW'(1)));
    sts.out_free    = !out_valid || !out_stall;
    sts.pend_last   = pend_last;
  end

  // Latched input transfer
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      pend_byte <= data_byte;
      pend_last <= final_byte;
    end
  end

  // Open run and group bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      run_byte   <= 8'd0;
      run_length <= 8'd0;
      fill       <= '0;
      idx        <= '0;
    end else begin
      if (cmd.run_inc) begin
        run_length <= run_length + 8'd1;
      end else if (cmd.run_load) begin
        run_byte   <= pend_byte;
        run_length <= 8'd1;
      end else if (cmd.run_dec) begin
        run_length <= run_length - 8'd1;
      end else if (cmd.run_clear) begin
        run_byte   <= 8'd0;
        run_length <= 8'd0;
      end
      if (cmd.fill_clear) begin
        fill <= '0;
        idx  <= '0;
      end else begin
        if (cmd.lit_write) begin
          fill <= fill + FW'(1);
        end
        if (cmd.emit_lit) begin
          idx <= idx + IW'(1);
        end
      end
    end
  end

  // Literal group store, registered read
  always_ff @(posedge clk) begin
    if (cmd.lit_write) begin
      store[fill[IW-1:0]] <= run_byte;
    end
    if (cmd.rd_issue) begin
      rd_data <= store[idx];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_lit || cmd.emit_tok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tok) begin
      token_kind  <= (run_byte == 8'd0) ? KIND_SKIP : KIND_REPEAT;
      token_value <= run_byte;
      token_count <= run_length;
      element_end <= 1'b1;
      stream_end  <= cmd.stream_last;
    end else if (cmd.emit_lit) begin
      token_kind  <= KIND_LITERAL;
      token_value <= rd_data;
      token_count <= 8'(fill);
      element_end <= sts.idx_last;
      stream_end  <= cmd.stream_last && sts.idx_last;
    end
  end

endmodule

FILE: hw/rtl/brle_ctrl.sv
module brle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                final_byte,
  input  brle_pkg::brle_sts_t sts,
  output brle_pkg::brle_cmd_t cmd
);
  import brle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_RD,
    S_LIT,
    S_TOK
  } state_t;

  // Where a group flush carries on
  typedef enum logic [1:0] {
    R_CLOSE,
    R_TOK,
    R_DONE
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;
  logic   phase, phase_next;   // 1 while closing out the image

  // no transfer is taken while in reset
  assign in_stall = rst || (state != S_IDLE);

  // Sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    phase_next = phase;
    cmd.stream_last = (ret == R_DONE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (sts.extend) begin
            cmd.run_inc = 1'b1;
            if (final_byte) begin
              phase_next = 1'b1;
              state_next = S_CLOSE;
            end
          end else begin
            phase_next = 1'b0;
            state_next = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (sts.run_zero) begin
          if (!phase) begin
            cmd.run_load = 1'b1;
            if (sts.pend_last) begin
              phase_next = 1'b1;
            end else begin
              state_next = S_IDLE;
            end
          end else if (sts.group_empty) begin
            cmd.run_clear = 1'b1;
            state_next    = S_IDLE;
          end else begin
            ret_next   = R_DONE;
            state_next = S_RD;
          end
        end else if (sts.run_long) begin
          if (sts.group_empty) begin
            state_next = S_TOK;
          end else begin
            ret_next   = R_TOK;
            state_next = S_RD;
          end
        end else if (sts.group_full) begin
          ret_next   = R_CLOSE;
          state_next = S_RD;
        end else begin
          cmd.lit_write = 1'b1;
          cmd.run_dec   = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LIT;
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.emit_lit = 1'b1;
          if (sts.idx_last) begin
            cmd.fill_clear = 1'b1;
            case (ret)
              R_CLOSE: state_next = S_CLOSE;
              R_TOK:   state_next = S_TOK;
              default: begin
                cmd.run_clear = 1'b1;
                state_next    = S_IDLE;
              end
            endcase
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_TOK: begin
        cmd.stream_last = phase;
        if (sts.out_free) begin
          cmd.emit_tok  = 1'b1;
          cmd.run_clear = 1'b1;
          state_next    = S_CLOSE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= R_DONE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      phase <= phase_next;
    end
  end

  // Results are loaded only into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_lit || cmd.emit_tok) |-> sts.out_free)
    else $error("result loaded over a waiting result");

  // Group never overfills
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.lit_write |-> !sts.group_full)
    else $error("literal written into a full group");

  // Tokens only for long runs, and only once the group is out
  a_tok_long: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_tok |-> (sts.run_long && sts.group_empty))
    else $error("token issued for a short run or with a pending group");

  // A literal result always comes from a non-empty group
  a_lit_group: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_lit |-> !sts.group_empty)
    else $error("literal issued from an empty group");

  // Back in idle after an image, nothing is left open
  a_image_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIT && cmd.emit_lit && sts.idx_last && ret == R_DONE)
      |=> (sts.run_zero && sts.group_empty))
    else $error("state left over after the final byte");

endmodule

FILE: test/byte_run_length_encoder_unit_test.sv
`timescale 1ns / 1ps

module byte_run_length_encoder_unit_test;
  import brle_pkg::*;

  localparam int GROUP_MAX = 16;
  localparam int RUN_LIMIT = 255;
  localparam int RUN_CAP = (RUN_LIMIT > COUNT_MAX) ? COUNT_MAX : RUN_LIMIT;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       is_final;
  } image_byte_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] count;
    logic       elem_end;
    logic       strm_end;
  } token_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] token_kind;
  logic [7:0] token_value;
  logic [7:0] token_count;
  logic       element_end;
  logic       stream_end;

  image_byte_t pending_bytes[$];
  token_t      expected_tokens[$];
  token_t      step_tokens[$];

  // encoder state mirrored by the predictor
  logic [7:0] open_byte = 8'h00;
  int         open_len = 0;
  logic [7:0] group_bytes[GROUP_MAX];
  int         group_fill = 0;

  int   fail_count = 0;
  int   idle_cycles = 0;
  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;
  int   in_gap = 0;
  int   out_hold = 0;
  logic in_calm = 1'b0;
  logic out_calm = 1'b0;

  byte_run_length_encoder_unit #(
    .LITERAL_GROUP_MAX(GROUP_MAX),
    .RUN_LIMIT(RUN_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .final_byte(final_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_value(token_value),
    .token_count(token_count),
    .element_end(element_end),
    .stream_end(stream_end)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void push_token(logic [1:0] kind, logic [7:0] value, int count,
                                     logic elem_end);
    token_t t;
    t.kind = kind;
    t.value = value;
    t.count = 8'(count);
    t.elem_end = elem_end;
    t.strm_end = 1'b0;
    step_tokens.push_back(t);
  endfunction

  // emit the pending literal group, one result per byte
  function automatic void flush_group();
    int i;
    for (i = 0; i < group_fill; i++)
      push_token(KIND_LITERAL, group_bytes[i], group_fill, i == group_fill - 1);
    group_fill = 0;
  endfunction

  // long runs become tokens, short ones join the literal group
  function automatic void close_run();
    int i;
    if (open_len > int'(LITERAL_RUN_MAX)) begin
      flush_group();
      if (open_byte == 8'h00)
        push_token(KIND_SKIP, 8'h00, open_len, 1'b1);
      else
        push_token(KIND_REPEAT, open_byte, open_len, 1'b1);
    end else begin
      for (i = 0; i < open_len; i++) begin
        if (group_fill >= GROUP_MAX)
          flush_group();
        group_bytes[group_fill] = open_byte;
        group_fill++;
      end
    end
    open_len = 0;
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic is_final);
    step_tokens.delete();
    if (open_len > 0 && b == open_byte && open_len < RUN_CAP) begin
      open_len++;
    end else begin
      close_run();
      open_byte = b;
      open_len = 1;
    end
    // end of image: close everything and mark the last result
    if (is_final) begin
      close_run();
      flush_group();
      if (step_tokens.size() > 0)
        step_tokens[step_tokens.size() - 1].strm_end = 1'b1;
      open_byte = 8'h00;
      open_len = 0;
      group_fill = 0;
    end
    foreach (step_tokens[i])
      expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3)
      return 8'h00;
    else if (sel == 3)
      return 8'hFF;
    else
      return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_run(logic [7:0] value, int len, logic ends_image);
    image_byte_t item;
    for (int k = 0; k < len; k++) begin
      item.value = value;
      item.is_final = ends_image && (k == len - 1);
      pending_bytes.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------- input driver

  // sample transfers on the rising edge
  always @(posedge clk) begin
    in_xfer <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      encode_byte(data_byte, final_byte);
  end

  // present the next byte on the falling edge, after a random gap
  always @(negedge clk) begin : input_driver
    image_byte_t item;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_xfer) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        item = pending_bytes.pop_front();
        in_valid <= 1'b1;
        data_byte <= item.value;
        final_byte <= item.is_final;
        if ($urandom_range(0, 31) == 0)
          in_calm = ~in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result side

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    token_t want;
    out_xfer <= !rst && out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("result with nothing expected: kind %0d value %0d count %0d",
               token_kind, token_value, token_count);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", 8'(want.kind), 8'(token_kind));
        check_field("token_value", want.value, token_value);
        check_field("token_count", want.count, token_count);
        check_field("element_end", 8'(want.elem_end), 8'(element_end));
        check_field("stream_end", 8'(want.strm_end), 8'(stream_end));
      end
    end
  end

  // hold off each result for a random number of cycles
  always @(negedge clk) begin : result_stall
    int hold;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_xfer) begin
      if ($urandom_range(0, 31) == 0)
        out_calm = ~out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 8);
      out_stall <= (hold > 0);
      out_hold <= (hold > 0) ? hold - 1 : 0;
    end else if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold <= out_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int n_rand;
    int n_runs;
    int mode;
    int sel;
    int len;

    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    final_byte = 1'b0;
    out_stall = 1'b0;

    // directed: lone byte, zero run at the end, repeat then literal,
    // a full literal group followed by a further pair
    add_run(8'hA5, 1, 1'b1);
    add_run(8'h00, 3, 1'b1);
    add_run(8'hFF, 4, 1'b0);
    add_run(8'h12, 1, 1'b1);
    for (int i = 1; i <= GROUP_MAX; i++)
      add_run(8'(i), 1, 1'b0);
    add_run(8'h80, 2, 1'b1);

    // random images; some are bursts of short runs to fill literal groups
    n_rand = 0;
    while (n_rand < 200) begin
      mode = $urandom_range(0, 4);
      n_runs = (mode == 0) ? $urandom_range(10, 36) : $urandom_range(1, 12);
      for (int r = 0; r < n_runs; r++) begin
        sel = $urandom_range(0, 19);
        if (mode == 0)
          len = (sel >= 16) ? 2 : 1;
        else if (sel < 9)
          len = 1;
        else if (sel < 13)
          len = 2;
        else if (sel < 19)
          len = $urandom_range(3, 9);
        else
          len = $urandom_range(10, 40);
        add_run(pick_byte(), len, r == n_runs - 1);
        n_rand += len;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // drain the stimulus, then the expected results, then a quiet tail
    while (pending_bytes.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_tokens.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
